/* hw/rtl/oaht_pkg.sv */
// shared types and constants for the open addressing hash table
// used by the controller, the datapath and the top level; no dependencies

package oaht_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 4096;
   localparam int KEY_W               = 64;
   localparam int VAL_W               = 64;
   localparam int PEAK_W              = 6;
   localparam int HITS_W              = 7;
   localparam int INSERT_LIMIT        = 64;
   localparam int LOOKUP_LIMIT        = 128;
   localparam int WORD_W              = KEY_W + VAL_W;

   localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_LOOKUP = 1'b1
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       hash1;
      logic       hash2;
      logic       hash3;
      logic       clear_step;
      logic       ram_read;
      logic       ram_write;
      logic       advance;
      logic       set_result;
      status_type result;
      logic       take_value;
      logic       out_load;
   } oaht_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_lookup;
      logic key_match;
      logic slot_empty;
      logic insert_last;
      logic lookup_last;
      logic clear_last;
   } oaht_sts_type;

endpackage

/* hw/rtl/oaht_ram.sv */
// generic single-clock ram, one write port and one registered read port
// no dependencies

module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/oaht_ctrl.sv */
// controller for the hash table: sequences clearing, hashing and probing
// depends on oaht_pkg

module oaht_ctrl
   import oaht_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  oaht_sts_type sts,
   output oaht_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH1,
      S_HASH2,
      S_HASH3,
      S_READ,
      S_CHECK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.result   = ST_OK;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_HASH1;
            end
         end
         S_HASH1: begin
            cmd.hash1 = 1'b1;
            state_in  = S_HASH2;
         end
         S_HASH2: begin
            cmd.hash2 = 1'b1;
            state_in  = S_HASH3;
         end
         S_HASH3: begin
            cmd.hash3 = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            cmd.ram_read = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_FINISH;
            if (!sts.is_lookup) begin
               if (sts.key_match || sts.slot_empty) begin
                  cmd.ram_write  = 1'b1;
                  cmd.set_result = 1'b1;
                  cmd.result     = ST_OK;
               end else if (sts.insert_last) begin
                  cmd.set_result = 1'b1;
                  cmd.result     = ST_FULL;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end else begin
               if (sts.key_match) begin
                  cmd.set_result = 1'b1;
                  cmd.result     = ST_OK;
                  cmd.take_value = 1'b1;
               end else if (sts.slot_empty || sts.lookup_last) begin
                  cmd.set_result = 1'b1;
                  cmd.result     = ST_MISS;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/oaht_dp.sv */
// datapath for the hash table: hash pipeline, probe registers, slot memory
// and result registers; depends on oaht_pkg and oaht_ram

module oaht_dp
   import oaht_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  oaht_cmd_type           cmd,
   output oaht_sts_type           sts,
   input  logic                   req_mode,
   input  logic [KEY_W-1:0]       req_lookup_key,
   input  logic [VAL_W-1:0]       req_new_value,
   output logic [1:0]             rsp_status,
   output logic [VAL_W-1:0]       rsp_read_value,
   output logic [PEAK_W-1:0]      rsp_max_collisions
);

   localparam int SLOT_BITS  = $clog2(TABLE_DEPTH);
   localparam int SLOT_COUNT = 1 << SLOT_BITS;
   localparam int SUM_W      = (SLOT_BITS > HITS_W) ? SLOT_BITS : HITS_W;

   logic                 mode_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VAL_W-1:0]     value_ff;
   logic [KEY_W-1:0]     hash_ff, hash_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [HITS_W-1:0]    hits_ff, hits_in, hits_nx;
   logic [PEAK_W-1:0]    peak_ff, peak_in;
   status_type           res_status_ff;
   logic [VAL_W-1:0]     res_value_ff;
   status_type           out_status_ff;
   logic [VAL_W-1:0]     out_value_ff;
   logic [PEAK_W-1:0]    out_peak_ff;

   logic [KEY_W-1:0]     mix_a, mix_b, mix_c;
   logic [SUM_W-1:0]     slot_sum;
   logic                 ram_wr_en;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WORD_W-1:0]    ram_rd_data;
   logic [KEY_W-1:0]     rd_key;
   logic [VAL_W-1:0]     rd_value;

   // wang mix split over the hash1, hash2 and hash3 steps, constant products as shift-adds
   always_comb begin
      mix_a = (~key_ff) + (key_ff << 21);
      mix_b = hash_ff + (hash_ff << 3) + (hash_ff << 8);
      mix_c = hash_ff + (hash_ff << 2) + (hash_ff << 4);
      mix_c = mix_c ^ (mix_c >> 28);
      hash_in = hash_ff;
      if (cmd.hash1) begin
         hash_in = mix_a ^ (mix_a >> 24);
      end else if (cmd.hash2) begin
         hash_in = mix_b ^ (mix_b >> 14);
      end
   end

   assign hits_nx  = hits_ff + HITS_W'(1);
   assign slot_sum = SUM_W'(slot_ff) + SUM_W'(hits_nx);

   always_comb begin
      slot_in = slot_ff;
      hits_in = hits_ff;
      peak_in = peak_ff;
      if (cmd.clear_step) begin
         slot_in = slot_ff + SLOT_BITS'(1);
      end else if (cmd.hash3) begin
         slot_in = SLOT_BITS'(mix_c + (mix_c << 31));
         hits_in = '0;
      end else if (cmd.advance) begin
         slot_in = slot_sum[SLOT_BITS-1:0];
         hits_in = hits_nx;
         if (!mode_ff && (HITS_W'(peak_ff) < hits_nx)) begin
            peak_in = PEAK_W'(hits_nx);
         end
      end
   end

   assign ram_wr_en   = cmd.clear_step || cmd.ram_write;
   assign ram_wr_data = cmd.clear_step ? {WORD_W{1'b1}} : {value_ff, key_ff};

   oaht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.ram_read),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_key   = ram_rd_data[KEY_W-1:0];
   assign rd_value = ram_rd_data[WORD_W-1:KEY_W];

   assign sts.is_lookup   = mode_ff;
   assign sts.key_match   = (rd_key == key_ff);
   assign sts.slot_empty  = (rd_key == EMPTY_KEY);
   assign sts.insert_last = (hits_ff == HITS_W'(INSERT_LIMIT - 1));
   assign sts.lookup_last = (hits_ff == HITS_W'(LOOKUP_LIMIT - 1));
   assign sts.clear_last  = (slot_ff == SLOT_BITS'(SLOT_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         peak_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         peak_ff <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      hits_ff <= hits_in;
      if (cmd.load_req) begin
         mode_ff  <= req_mode;
         key_ff   <= req_lookup_key;
         value_ff <= req_new_value;
      end
      if (cmd.set_result) begin
         res_status_ff <= cmd.result;
         res_value_ff  <= cmd.take_value ? rd_value : {VAL_W{1'b1}};
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
         out_peak_ff   <= peak_ff;
      end
   end

   assign rsp_status         = out_status_ff;
   assign rsp_read_value     = out_value_ff;
   assign rsp_max_collisions = out_peak_ff;

endmodule

/* hw/rtl/open_addressing_hash_table.sv */
// open addressing hash table, top level
// depends on oaht_pkg, oaht_ctrl, oaht_dp (which holds oaht_ram)
//
// usage
//   req channel: one item per insert or lookup; tuser carries the mode
//   (0 insert or update, 1 lookup), tdata the key and the value to store
//   rsp channel: exactly one item per request, in request order; tuser
//   carries the status (0 stored or found, 1 not found, 2 insert failed),
//   tdata the value read and the running peak of insert collisions
// sequence
//   an item is hashed in the hash1, hash2 and hash3 steps, then each probe
//   of the slot memory is a registered read followed by a compare, and
//   last the result is loaded into the output register; a new item is
//   taken only after the previous result is loaded, not while an item is
//   still being hashed or probed
//   probes are at most 64 for an insert and 128 for a lookup
// reset
//   after reset the slot memory is swept to all ones, one slot a cycle,
//   over all 2**clog2(TABLE_DEPTH) slots (4096 by default); req_tready stays low
// stalls
//   a result waits in the output register while rsp_tready is low; the next
//   item may be accepted and probed meanwhile, and holds before loading its
//   result until the output register is free

module open_addressing_hash_table
   import oaht_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // lookup_key [63:0], new_value [127:64]
   input  logic         req_tuser,   // mode [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // read_value [63:0], max_collisions [69:64], zeros
   output logic [1:0]   rsp_tuser    // status [1:0]
);

   oaht_cmd_type        cmd;
   oaht_sts_type        sts;
   logic [1:0]          rsp_status;
   logic [VAL_W-1:0]    rsp_read_value;
   logic [PEAK_W-1:0]   rsp_max_collisions;

   oaht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   oaht_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_tuser),
      .req_lookup_key     (req_tdata[63:0]),
      .req_new_value      (req_tdata[127:64]),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_max_collisions (rsp_max_collisions)
   );

   assign rsp_tdata = {2'b00, rsp_max_collisions, rsp_read_value};
   assign rsp_tuser = rsp_status;

endmodule
